FILE: rtl/bchd_pkg.sv
// Shared types and constants of the button click and hold detector.
package bchd_pkg;

   // Field and register widths
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned DebWidth   = 8;
   localparam int unsigned GapWidth   = 16;
   localparam int unsigned TipWidth   = 16;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 16;

   // Register indexes of the configuration port
   localparam logic [CsrIdxWidth-1:0] CSR_PRESSED_LEVEL = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE_MS   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_CLICK_GAP_MS  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_TIP_INTERVAL  = 2'd3;

   // Register reset values
   localparam logic                  RST_PRESSED_LEVEL = 1'b0;
   localparam logic [DebWidth-1:0]   RST_DEBOUNCE_MS   = 8'd10;
   localparam logic [GapWidth-1:0]   RST_CLICK_GAP_MS  = 16'd300;
   localparam logic [TipWidth-1:0]   RST_TIP_INTERVAL  = 16'd1000;

   // Key phases
   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_HELD     = 2'd2,
      PH_WAIT     = 2'd3
   } phase_type;

   // Event codes of a result beat
   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_TIP    = 2'd1,
      EV_FINISH = 2'd2
   } event_type;

   // Configuration registers as seen by the controller
   typedef struct packed {
      logic                pressed_level;
      logic [DebWidth-1:0] debounce_ms;
      logic [GapWidth-1:0] click_gap_ms;
      logic [TipWidth-1:0] tip_interval_ms;
   } cfg_type;

   // One result beat
   typedef struct packed {
      event_type             event_code;
      logic [TimeWidth-1:0]  press_duration_ms;
      logic [CountWidth-1:0] click_count;
   } result_type;

endpackage

FILE: rtl/bchd_req_if.sv
// Input channel: one sampled key level per millisecond tick.
interface bchd_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

FILE: rtl/bchd_rsp_if.sv
// Result channel: one event beat per tick.
interface bchd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      event_code;
   logic [bchd_pkg::TimeWidth-1:0]  press_duration_ms;
   logic [bchd_pkg::CountWidth-1:0] click_count;

   modport source (output valid, output event_code, output press_duration_ms,
                   output click_count, input ready);
   modport sink   (input valid, input event_code, input press_duration_ms,
                   input click_count, output ready);
endinterface

FILE: rtl/bchd_ctrl.sv
// Key phase machine, tick counter and time marks; computes one result per tick.
module bchd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 down,
   input  bchd_pkg::cfg_type    cfg,
   output bchd_pkg::result_type result
);

   bchd_pkg::phase_type phase_ff, phase_in;
   logic [bchd_pkg::CountWidth-1:0] clicks_ff, clicks_in;
   logic [bchd_pkg::TimeWidth-1:0]  now_ff, now_in;
   logic [bchd_pkg::TimeWidth-1:0]  mark_ff, mark_in;
   logic [bchd_pkg::TimeWidth-1:0]  press_ff, press_in;
   logic [bchd_pkg::TimeWidth-1:0]  release_ff, release_in;

   logic [bchd_pkg::TimeWidth-1:0] since_mark;
   logic [bchd_pkg::TimeWidth-1:0] since_release;
   logic deb_done;
   logic tip_due;
   logic gap_done;

   // Elapsed times, wrapping, compared strictly above the thresholds
   assign since_mark    = now_ff - mark_ff;
   assign since_release = now_ff - release_ff;
   assign deb_done = since_mark >
      {{(bchd_pkg::TimeWidth-bchd_pkg::DebWidth){1'b0}}, cfg.debounce_ms};
   assign tip_due  = since_mark >
      {{(bchd_pkg::TimeWidth-bchd_pkg::TipWidth){1'b0}}, cfg.tip_interval_ms};
   assign gap_done = since_release >
      {{(bchd_pkg::TimeWidth-bchd_pkg::GapWidth){1'b0}}, cfg.click_gap_ms};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         bchd_pkg::PH_IDLE: begin
            if (down) phase_in = bchd_pkg::PH_DEBOUNCE;
         end
         bchd_pkg::PH_DEBOUNCE: begin
            if (deb_done) phase_in = down ? bchd_pkg::PH_HELD : bchd_pkg::PH_WAIT;
         end
         bchd_pkg::PH_HELD: begin
            if (!tip_due && !down) phase_in = bchd_pkg::PH_DEBOUNCE;
         end
         bchd_pkg::PH_WAIT: begin
            if (gap_done) phase_in = bchd_pkg::PH_IDLE;
            else if (down) phase_in = bchd_pkg::PH_DEBOUNCE;
         end
         default: phase_in = bchd_pkg::PH_IDLE;
      endcase
   end

   // Time marks, click count and the result of this tick
   always_comb begin
      clicks_in  = clicks_ff;
      mark_in    = mark_ff;
      press_in   = press_ff;
      release_in = release_ff;
      now_in     = now_ff + 1'b1;
      result.event_code        = bchd_pkg::EV_NONE;
      result.press_duration_ms = '0;
      result.click_count       = '0;
      unique case (phase_ff)
         bchd_pkg::PH_IDLE: begin
            if (down) begin
               clicks_in  = '0;
               press_in   = '0;
               release_in = '0;
               mark_in    = now_ff;
            end
         end
         bchd_pkg::PH_DEBOUNCE: begin
            if (deb_done) begin
               if (down) begin
                  clicks_in = clicks_ff + 1'b1;
                  mark_in   = now_ff;
                  press_in  = now_ff;
               end else begin
                  release_in = now_ff;
               end
            end
         end
         bchd_pkg::PH_HELD: begin
            // a tip tick skips the release check
            if (tip_due) begin
               mark_in = now_ff;
               result.event_code = bchd_pkg::EV_TIP;
            end else if (!down) begin
               mark_in = now_ff;
            end
         end
         bchd_pkg::PH_WAIT: begin
            if (gap_done) begin
               result.event_code        = bchd_pkg::EV_FINISH;
               result.press_duration_ms = release_ff - press_ff;
               result.click_count       = clicks_ff;
            end else if (down) begin
               mark_in = now_ff;
            end
         end
         default: ;
      endcase
   end

   // Advance state on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bchd_pkg::PH_IDLE;
         clicks_ff  <= '0;
         now_ff     <= '0;
         mark_ff    <= '0;
         press_ff   <= '0;
         release_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         clicks_ff  <= clicks_in;
         now_ff     <= now_in;
         mark_ff    <= mark_in;
         press_ff   <= press_in;
         release_ff <= release_in;
      end
   end

endmodule

FILE: rtl/button_click_hold_detector.sv
// Top level of the button click and hold detector: config registers and result register.
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------
//  req_if   | in  | pin_level, one beat per millisecond tick
//  rsp_if   | out | event_code, press_duration_ms, click_count
//  csr_*    | in  | csr_we, csr_index, csr_wdata (write only)
//
// One tick per clock unless a result beat is stalled: the tick is evaluated in the
// cycle it is accepted and its result beat is registered, visible from the next cycle.
// Reset (synchronous) returns the phase to idle, clears the tick counter and
// marks, and loads the register defaults.
// A stalled result beat holds the register; a new tick is still taken in the
// same cycle the held beat is drained.
module button_click_hold_detector (
   input  logic                                clock,
   input  logic                                reset,
   bchd_req_if.sink                            req_if,
   bchd_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [bchd_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [bchd_pkg::CsrDataWidth-1:0]   csr_wdata
);

   bchd_pkg::cfg_type    cfg_ff;
   bchd_pkg::result_type result;
   bchd_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 accept;
   logic                 down;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressed_level   <= bchd_pkg::RST_PRESSED_LEVEL;
         cfg_ff.debounce_ms     <= bchd_pkg::RST_DEBOUNCE_MS;
         cfg_ff.click_gap_ms    <= bchd_pkg::RST_CLICK_GAP_MS;
         cfg_ff.tip_interval_ms <= bchd_pkg::RST_TIP_INTERVAL;
      end else if (csr_we) begin
         unique case (csr_index)
            bchd_pkg::CSR_PRESSED_LEVEL: cfg_ff.pressed_level <= csr_wdata[0];
            bchd_pkg::CSR_DEBOUNCE_MS:
               cfg_ff.debounce_ms <= csr_wdata[bchd_pkg::DebWidth-1:0];
            bchd_pkg::CSR_CLICK_GAP_MS:
               cfg_ff.click_gap_ms <= csr_wdata[bchd_pkg::GapWidth-1:0];
            bchd_pkg::CSR_TIP_INTERVAL:
               cfg_ff.tip_interval_ms <= csr_wdata[bchd_pkg::TipWidth-1:0];
            default: ;
         endcase
      end
   end

   // Take a tick whenever the result register is free or draining
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign down         = (req_if.pin_level == cfg_ff.pressed_level);

   bchd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .down   (down),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= result;
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.event_code        = rsp_ff.event_code;
   assign rsp_if.press_duration_ms = rsp_ff.press_duration_ms;
   assign rsp_if.click_count       = rsp_ff.click_count;

endmodule

FILE: bench/bchd_event_checker.sv
// Checker of the click and hold detector: mirrors the registers, predicts and compares beats.
module bchd_event_checker (
   input  logic                                clock,
   input  logic                                reset,
   bchd_req_if                                 req_if,
   bchd_rsp_if                                 rsp_if,
   input  logic                                csr_we,
   input  logic [bchd_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [bchd_pkg::CsrDataWidth-1:0]   csr_wdata,
   output int unsigned                         pending,
   output int unsigned                         failures
);

   // Register mirror and key tracking state
   bchd_pkg::cfg_type                cfg;
   bchd_pkg::phase_type              key_phase;
   logic [bchd_pkg::CountWidth-1:0]  clicks_seen;
   logic [bchd_pkg::TimeWidth-1:0]   tick_ms;
   logic [bchd_pkg::TimeWidth-1:0]   mark_ms;
   logic [bchd_pkg::TimeWidth-1:0]   press_ms;
   logic [bchd_pkg::TimeWidth-1:0]   release_ms;

   bchd_pkg::result_type expected_events[$];

   initial begin
      pending  = 0;
      failures = 0;
   end

   // Advance the key tracker by one millisecond tick and return the beat it causes
   function automatic bchd_pkg::result_type next_key_event(input logic pin);
      bchd_pkg::result_type           ev;
      logic                           down;
      logic [bchd_pkg::TimeWidth-1:0] t;
      logic [bchd_pkg::TimeWidth-1:0] elapsed;
      ev = '0;
      ev.event_code = bchd_pkg::EV_NONE;
      t = tick_ms;
      down = (pin == cfg.pressed_level);
      case (key_phase)
         bchd_pkg::PH_IDLE: begin
            if (down) begin
               clicks_seen = '0;
               press_ms    = '0;
               release_ms  = '0;
               mark_ms     = t;
               key_phase   = bchd_pkg::PH_DEBOUNCE;
            end
         end
         bchd_pkg::PH_DEBOUNCE: begin
            elapsed = t - mark_ms;
            if (elapsed > cfg.debounce_ms) begin
               if (down) begin
                  key_phase   = bchd_pkg::PH_HELD;
                  clicks_seen = clicks_seen + 1'b1;
                  mark_ms     = t;
                  press_ms    = t;
               end else begin
                  key_phase  = bchd_pkg::PH_WAIT;
                  release_ms = t;
               end
            end
         end
         bchd_pkg::PH_HELD: begin
            // a tip tick skips the release check
            elapsed = t - mark_ms;
            if (elapsed > cfg.tip_interval_ms) begin
               mark_ms = t;
               ev.event_code = bchd_pkg::EV_TIP;
            end else if (!down) begin
               mark_ms   = t;
               key_phase = bchd_pkg::PH_DEBOUNCE;
            end
         end
         default: begin
            elapsed = t - release_ms;
            if (elapsed > cfg.click_gap_ms) begin
               key_phase = bchd_pkg::PH_IDLE;
               ev.event_code        = bchd_pkg::EV_FINISH;
               ev.press_duration_ms = release_ms - press_ms;
               ev.click_count       = clicks_seen;
            end else if (down) begin
               mark_ms   = t;
               key_phase = bchd_pkg::PH_DEBOUNCE;
            end
         end
      endcase
      tick_ms = tick_ms + 1'b1;
      return ev;
   endfunction

   // Track registers, predict on each input beat, check each result beat
   always @(posedge clock) begin : track
      bchd_pkg::result_type want;
      if (reset) begin
         cfg.pressed_level   = bchd_pkg::RST_PRESSED_LEVEL;
         cfg.debounce_ms     = bchd_pkg::RST_DEBOUNCE_MS;
         cfg.click_gap_ms    = bchd_pkg::RST_CLICK_GAP_MS;
         cfg.tip_interval_ms = bchd_pkg::RST_TIP_INTERVAL;
         key_phase   = bchd_pkg::PH_IDLE;
         clicks_seen = '0;
         tick_ms     = '0;
         mark_ms     = '0;
         press_ms    = '0;
         release_ms  = '0;
         expected_events.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               bchd_pkg::CSR_PRESSED_LEVEL:
                  cfg.pressed_level = csr_wdata[0];
               bchd_pkg::CSR_DEBOUNCE_MS:
                  cfg.debounce_ms = csr_wdata[bchd_pkg::DebWidth-1:0];
               bchd_pkg::CSR_CLICK_GAP_MS:
                  cfg.click_gap_ms = csr_wdata[bchd_pkg::GapWidth-1:0];
               bchd_pkg::CSR_TIP_INTERVAL:
                  cfg.tip_interval_ms = csr_wdata[bchd_pkg::TipWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_events.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result beat: event %0d duration %0d count %0d",
                           rsp_if.event_code, rsp_if.press_duration_ms, rsp_if.click_count);
            end else begin
               want = expected_events.pop_front();
               if (rsp_if.event_code !== want.event_code ||
                   rsp_if.press_duration_ms !== want.press_duration_ms ||
                   rsp_if.click_count !== want.click_count) begin
                  failures++;
                  if (failures <= 10)
                     $display("result mismatch: expected event %0d duration %0d count %0d, %s",
                              want.event_code, want.press_duration_ms, want.click_count,
                              $sformatf("got event %0d duration %0d count %0d",
                                        rsp_if.event_code, rsp_if.press_duration_ms,
                                        rsp_if.click_count));
               end
            end
         end
         if (req_if.valid && req_if.ready)
            expected_events.push_back(next_key_event(req_if.pin_level));
      end
      pending = expected_events.size();
   end

endmodule

FILE: bench/tb_top.sv
// Top of the click and hold detector bench: clock, reset, stimulus, result drain and verdict.
module tb_top;

   localparam int unsigned StallLimit = 2000;
   localparam int unsigned ClickBurst = 260;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_we;
   logic [bchd_pkg::CsrIdxWidth-1:0]  csr_index;
   logic [bchd_pkg::CsrDataWidth-1:0] csr_wdata;

   int unsigned pending;
   int unsigned failures;
   int unsigned stall_cycles = 0;
   int unsigned sent_ticks = 0;
   int unsigned drained_beats = 0;
   bit          send_idle = 1'b1;
   bit          drain_idle = 1'b1;

   // current settings, used to shape key sequences
   logic                          cur_pl;
   logic [bchd_pkg::DebWidth-1:0] cur_deb;
   logic [bchd_pkg::GapWidth-1:0] cur_gap;
   logic [bchd_pkg::TipWidth-1:0] cur_tip;

   bchd_req_if req_if ();
   bchd_rsp_if rsp_if ();

   button_click_hold_detector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bchd_event_checker checker_inst (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .failures  (failures)
   );

   always #5 clock = ~clock;

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || csr_we || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Drain result beats with random stalls and two long hold-offs
   initial begin : rsp_drain
      int unsigned hold;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (drained_beats == 400 || drained_beats == 1500)
            hold = 90;
         else
            hold = drain_idle ? $urandom_range(0, 5) : 0;
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         drained_beats++;
         if (drained_beats % 64 == 0)
            drain_idle = ($urandom_range(0, 3) != 0);
         @(negedge clock);
      end
   end

   // Offer one tick beat and hold it until taken; returns at a falling edge
   task automatic send_tick(input logic pin);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.pin_level <= pin;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      sent_ticks++;
      if (sent_ticks % 50 == 0)
         send_idle = ($urandom_range(0, 3) != 0);
      @(negedge clock);
   endtask

   // Send n ticks with the key down or up under the current polarity
   task automatic send_level(input bit down, input int unsigned n);
      repeat (n) send_tick(down ? cur_pl : ~cur_pl);
   endtask

   // Drop valid and wait until every result beat has come back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic csr_put(input logic [bchd_pkg::CsrIdxWidth-1:0] idx,
                          input logic [bchd_pkg::CsrDataWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Write all four registers while the block is idle
   task automatic apply_settings(input logic pl, input logic [bchd_pkg::DebWidth-1:0] deb,
                                 input logic [bchd_pkg::GapWidth-1:0] gap,
                                 input logic [bchd_pkg::TipWidth-1:0] tip);
      wait_idle();
      csr_put(bchd_pkg::CSR_PRESSED_LEVEL, {{(bchd_pkg::CsrDataWidth-1){1'b0}}, pl});
      csr_put(bchd_pkg::CSR_DEBOUNCE_MS,
              {{(bchd_pkg::CsrDataWidth-bchd_pkg::DebWidth){1'b0}}, deb});
      csr_put(bchd_pkg::CSR_CLICK_GAP_MS, gap);
      csr_put(bchd_pkg::CSR_TIP_INTERVAL, tip);
      csr_we  <= 1'b0;
      cur_pl  = pl;
      cur_deb = deb;
      cur_gap = gap;
      cur_tip = tip;
   endtask

   // Mostly press/release sequences sized around the settings, some noise
   task automatic run_phase(input int unsigned n);
      int unsigned first;
      int unsigned hi;
      int unsigned hold;
      first = sent_ticks;
      while (sent_ticks - first < n) begin
         if ($urandom_range(0, 9) < 8) begin
            hi = int'(cur_deb) + 3;
            if ($urandom_range(0, 2) == 0)
               hi = hi + 2 * int'(cur_tip);
            if (hi > 400) hi = 400;
            hold = $urandom_range(1, hi);
            if ($urandom_range(0, 3) == 0) begin
               // bounce in the middle of the press
               send_level(1'b1, hold / 2);
               send_level(1'b0, 1);
               send_level(1'b1, hold - hold / 2);
            end else begin
               send_level(1'b1, hold);
            end
            hi = int'(cur_deb) + int'(cur_gap) + 4;
            if (hi > 400) hi = 400;
            send_level(1'b0, $urandom_range(1, hi));
         end else begin
            repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Directed ticks: a press with a tip, a double click that finishes, then a
   // release that lands on a tip tick
   localparam logic [26:0] DirectedPins = 27'b0111111110011000000_11111100;

   initial begin : stimulus
      req_if.valid     = 1'b0;
      req_if.pin_level = 1'b0;
      csr_we           = 1'b0;
      csr_index        = bchd_pkg::CSR_PRESSED_LEVEL;
      csr_wdata        = '0;
      cur_pl  = bchd_pkg::RST_PRESSED_LEVEL;
      cur_deb = bchd_pkg::RST_DEBOUNCE_MS;
      cur_gap = bchd_pkg::RST_CLICK_GAP_MS;
      cur_tip = bchd_pkg::RST_TIP_INTERVAL;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // start on the reset settings
      run_phase(60);

      apply_settings(1'b1, 8'd1, 16'd2, 16'd3);
      for (int i = 26; i >= 0; i--)
         send_tick(DirectedPins[i]);

      // lowest and highest settings
      apply_settings(1'b0, 8'd0, 16'd0, 16'd0);
      run_phase(120);
      apply_settings(1'b1, 8'd255, 16'd65535, 16'd65535);
      run_phase(200);

      // long click burst so the click count wraps: after the first press,
      // each down tick confirms a click and each up tick starts a release
      apply_settings(1'($urandom_range(0, 1)), 8'd0, 16'd40, 16'd65535);
      send_level(1'b0, 50);
      send_level(1'b1, 1);
      repeat (ClickBurst) begin
         send_level(1'b1, 1);
         send_level(1'b0, 1);
      end
      send_level(1'b0, 45);

      // random settings with small thresholds
      repeat (4) begin
         apply_settings(1'($urandom_range(0, 1)), 8'($urandom_range(0, 6)),
                        16'($urandom_range(0, 24)), 16'($urandom_range(0, 30)));
         run_phase(120);
      end

      wait_idle();
      repeat (4) @(negedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
